@@ rtl/core/iso8601_timestamp_to_epoch_defines.svh @@
// Assertion macros for the ISO 8601 timestamp converter.
// Used by iso8601_epoch in rtl/core; expects clk and rst in scope.
`ifndef ISO8601_TIMESTAMP_TO_EPOCH_DEFINES_SVH
`define ISO8601_TIMESTAMP_TO_EPOCH_DEFINES_SVH

// Same-cycle implication
`define ISO8601_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("iso8601: implication check failed");

// Next-cycle implication
`define ISO8601_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("iso8601: next-cycle check failed");

`endif

@@ rtl/core/iso8601_pkg.sv @@
// Shared types, character codes and calendar tables for the ISO 8601 converter.
// No dependencies.
package iso8601_pkg;

  localparam int ACC_W  = 40;   // multiply-accumulate register
  localparam int OP_A_W = 24;
  localparam int OP_B_W = 19;
  localparam int PROD_W = OP_A_W + OP_B_W;

  localparam logic [4:0] POS_LIMIT = 5'd25;
  localparam logic [4:0] LEN_UTC   = 5'd20;
  localparam logic [4:0] LEN_ZONE  = 5'd25;

  localparam logic [7:0] CH_DASH  = 8'h2D;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_T     = 8'h54;
  localparam logic [7:0] CH_Z     = 8'h5A;

  localparam logic [1:0] ZK_NONE  = 2'd0;
  localparam logic [1:0] ZK_Z     = 2'd1;
  localparam logic [1:0] ZK_PLUS  = 2'd2;
  localparam logic [1:0] ZK_MINUS = 2'd3;

  localparam int DAYS_PER_ERA  = 146097;
  localparam int DAYS_TO_EPOCH = 719468;
  localparam int DAYS_PER_YEAR = 365;
  localparam int YEARS_PER_ERA = 400;
  localparam int SECS_PER_DAY  = 86400;
  localparam int SECS_PER_HOUR = 3600;
  localparam int SECS_PER_MIN  = 60;

  typedef struct packed {
    logic [13:0] year;
    logic [6:0]  month;
    logic [6:0]  day;
    logic [6:0]  hour;
    logic [6:0]  minute;
    logic [6:0]  second;
    logic [6:0]  zone_hours;
    logic [6:0]  zone_minutes;
    logic [1:0]  zone_kind;
    logic [4:0]  length;
    logic        error;
  } parse_t;

  function automatic logic [4:0] month_days(input logic [3:0] m, input logic leap);
    logic [4:0] d;
    case (m)
      4'd2:                      d = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:   d = 5'd30;
      4'd1, 4'd3, 4'd5, 4'd7,
      4'd8, 4'd10, 4'd12:        d = 5'd31;
      default:                   d = 5'd0;
    endcase
    return d;
  endfunction

  // (153 * mi + 2) / 5, March-based month index
  function automatic logic [8:0] doy_start(input logic [3:0] mi);
    logic [8:0] d;
    case (mi)
      4'd0:    d = 9'd0;
      4'd1:    d = 9'd31;
      4'd2:    d = 9'd61;
      4'd3:    d = 9'd92;
      4'd4:    d = 9'd122;
      4'd5:    d = 9'd153;
      4'd6:    d = 9'd184;
      4'd7:    d = 9'd214;
      4'd8:    d = 9'd245;
      4'd9:    d = 9'd275;
      4'd10:   d = 9'd306;
      4'd11:   d = 9'd337;
      default: d = 9'd0;
    endcase
    return d;
  endfunction

  // yoe / 100 for yoe < 400
  function automatic logic [1:0] cent_of(input logic [8:0] yoe);
    logic [1:0] c;
    if (yoe < 9'd100) begin
      c = 2'd0;
    end else if (yoe < 9'd200) begin
      c = 2'd1;
    end else if (yoe < 9'd300) begin
      c = 2'd2;
    end else begin
      c = 2'd3;
    end
    return c;
  endfunction

endpackage

@@ rtl/core/iso8601_parse.sv @@
// Character parser: position counter, decimal accumulators and format checks.
// Depends on iso8601_pkg.
module iso8601_parse (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [7:0]          s_tdata,   // [7:0] char_byte
  input  logic                s_tlast,   // last_char
  input  logic                done,
  output logic                start,
  output iso8601_pkg::parse_t fields
);
  import iso8601_pkg::*;

  logic       busy;
  logic       accept;
  logic       digit;
  logic [3:0] dval;
  parse_t     f;

  assign s_tready = !busy;
  assign accept   = s_tvalid && s_tready;
  assign digit    = s_tdata inside {[8'h30:8'h39]};
  assign dval     = s_tdata[3:0];
  assign fields   = f;

  function automatic logic [6:0] acc10(input logic [6:0] acc, input logic [3:0] d);
    return 7'({acc, 3'b000} + {acc, 1'b0} + {3'd0, d});
  endfunction

  always_ff @(posedge clk) begin
    if (rst || done) begin
      f     <= '0;
      busy  <= 1'b0;
      start <= 1'b0;
    end else begin
      start <= accept && s_tlast;
      if (accept) begin
        busy     <= s_tlast;
        f.length <= (f.length == POS_LIMIT) ? POS_LIMIT : f.length + 5'd1;
        case (f.length)
          5'd0, 5'd1, 5'd2, 5'd3: begin
            if (digit) f.year <= 14'({f.year, 3'b000} + {f.year, 1'b0} + {10'd0, dval});
            else f.error <= 1'b1;
          end
          5'd4, 5'd7: begin
            if (s_tdata != CH_DASH) f.error <= 1'b1;
          end
          5'd10: begin
            if (s_tdata != CH_T) f.error <= 1'b1;
          end
          5'd13, 5'd16, 5'd22: begin
            if (s_tdata != CH_COLON) f.error <= 1'b1;
          end
          5'd5, 5'd6: begin
            if (digit) f.month <= acc10(f.month, dval);
            else f.error <= 1'b1;
          end
          5'd8, 5'd9: begin
            if (digit) f.day <= acc10(f.day, dval);
            else f.error <= 1'b1;
          end
          5'd11, 5'd12: begin
            if (digit) f.hour <= acc10(f.hour, dval);
            else f.error <= 1'b1;
          end
          5'd14, 5'd15: begin
            if (digit) f.minute <= acc10(f.minute, dval);
            else f.error <= 1'b1;
          end
          5'd17, 5'd18: begin
            if (digit) f.second <= acc10(f.second, dval);
            else f.error <= 1'b1;
          end
          5'd19: begin
            if (s_tdata == CH_Z) f.zone_kind <= ZK_Z;
            else if (s_tdata == CH_PLUS) f.zone_kind <= ZK_PLUS;
            else if (s_tdata == CH_DASH) f.zone_kind <= ZK_MINUS;
            else f.error <= 1'b1;
          end
          5'd20, 5'd21: begin
            if (digit) f.zone_hours <= acc10(f.zone_hours, dval);
            else f.error <= 1'b1;
          end
          5'd23, 5'd24: begin
            if (digit) f.zone_minutes <= acc10(f.zone_minutes, dval);
            else f.error <= 1'b1;
          end
          default: begin
            f.error <= 1'b1;
          end
        endcase
      end
    end
  end

endmodule

@@ rtl/core/iso8601_epoch.sv @@
// Conversion sequencer: era division, date checks and a shared multiply-accumulate.
// Depends on iso8601_pkg and iso8601_timestamp_to_epoch_defines.svh.
`include "iso8601_timestamp_to_epoch_defines.svh"

module iso8601_epoch (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  iso8601_pkg::parse_t fields,
  output logic                done,
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [39:0]         m_tdata,   // [38:0] epoch_seconds, [39] zero
  output logic                m_tuser    // valid_res
);
  import iso8601_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_DIV  = 3'd1;
  localparam logic [2:0] ST_CHK  = 3'd2;
  localparam logic [2:0] ST_MAC  = 3'd3;
  localparam logic [2:0] ST_OUT  = 3'd4;

  localparam logic [3:0] STEP_LAST = 4'd9;

  logic [2:0]              state;
  logic [4:0]              q;
  logic [13:0]             r;
  logic [3:0]              step;
  logic signed [5:0]       era;
  logic [8:0]              yoe;
  logic [3:0]              mi;
  logic                    ok;
  logic signed [ACC_W-1:0] acc;

  logic                    leap;
  logic [4:0]              dim;
  logic                    date_ok;
  logic                    base_sel;
  logic signed [OP_A_W-1:0] op_a;
  logic signed [OP_B_W-1:0] op_b;
  logic signed [PROD_W-1:0] prod;
  logic signed [ACC_W-1:0]  sum;
  logic [9:0]               small_sum;

  // r < 400 here, so r%100 == 0 means r is 0, 100, 200 or 300
  assign leap = (fields.year[1:0] == 2'b00) &&
                !(r inside {14'd100, 14'd200, 14'd300});
  assign dim  = month_days(fields.month[3:0], leap);

  always_comb begin
    date_ok = 1'b1;
    if (fields.error) date_ok = 1'b0;
    if (!((fields.length == LEN_UTC && fields.zone_kind == ZK_Z) ||
          (fields.length == LEN_ZONE &&
           (fields.zone_kind == ZK_PLUS || fields.zone_kind == ZK_MINUS))))
      date_ok = 1'b0;
    if (!(fields.month inside {[7'd1:7'd12]})) date_ok = 1'b0;
    if (fields.day == 7'd0 || fields.day > {2'b00, dim}) date_ok = 1'b0;
    if (fields.hour > 7'd23 || fields.minute > 7'd59 || fields.second > 7'd60)
      date_ok = 1'b0;
    if (fields.length == LEN_ZONE &&
        (fields.zone_hours > 7'd23 || fields.zone_minutes > 7'd59))
      date_ok = 1'b0;
  end

  assign small_sum = 10'(yoe >> 2) + {1'b0, doy_start(mi)} + {3'd0, fields.day}
                   - 10'd1 - {8'd0, cent_of(yoe)};

  always_comb begin
    base_sel = 1'b1;
    op_a     = '0;
    op_b     = '0;
    case (step)
      4'd0: begin
        base_sel = 1'b0;
        op_a     = OP_A_W'(era);
        op_b     = OP_B_W'(DAYS_PER_ERA);
      end
      4'd1: begin
        op_a = OP_A_W'(yoe);
        op_b = OP_B_W'(DAYS_PER_YEAR);
      end
      4'd2: begin
        op_a = OP_A_W'(small_sum);
        op_b = OP_B_W'(1);
      end
      4'd3: begin
        op_a = OP_A_W'(-DAYS_TO_EPOCH);
        op_b = OP_B_W'(1);
      end
      4'd4: begin
        base_sel = 1'b0;
        op_a     = acc[OP_A_W-1:0];
        op_b     = OP_B_W'(SECS_PER_DAY);
      end
      4'd5: begin
        op_a = OP_A_W'(fields.hour);
        op_b = OP_B_W'(SECS_PER_HOUR);
      end
      4'd6: begin
        op_a = OP_A_W'(fields.minute);
        op_b = OP_B_W'(SECS_PER_MIN);
      end
      4'd7: begin
        op_a = OP_A_W'(fields.second);
        op_b = OP_B_W'(1);
      end
      4'd8: begin
        op_a = OP_A_W'(fields.zone_hours);
        op_b = (fields.zone_kind == ZK_PLUS) ? OP_B_W'(-SECS_PER_HOUR)
                                             : OP_B_W'(SECS_PER_HOUR);
      end
      4'd9: begin
        op_a = OP_A_W'(fields.zone_minutes);
        op_b = (fields.zone_kind == ZK_PLUS) ? OP_B_W'(-SECS_PER_MIN)
                                             : OP_B_W'(SECS_PER_MIN);
      end
      default: begin
        base_sel = 1'b0;
      end
    endcase
  end

  assign prod = op_a * op_b;
  assign sum  = (base_sel ? acc : '0) + prod[ACC_W-1:0];
  assign done = (state == ST_OUT) && (!m_tvalid || m_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      if (done) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (start) begin
            r     <= fields.year;
            q     <= '0;
            state <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (r >= 14'(YEARS_PER_ERA)) begin
            r <= r - 14'(YEARS_PER_ERA);
            q <= q + 5'd1;
          end else begin
            state <= ST_CHK;
          end
        end
        ST_CHK: begin
          acc  <= '0;
          step <= '0;
          ok   <= date_ok;
          if (fields.month <= 7'd2) begin
            mi <= 4'(fields.month + 7'd9);
            if (r == 14'd0) begin
              era <= 6'(q) - 6'sd1;
              yoe <= 9'(YEARS_PER_ERA - 1);
            end else begin
              era <= 6'(q);
              yoe <= 9'(r - 14'd1);
            end
          end else begin
            mi  <= 4'(fields.month - 7'd3);
            era <= 6'(q);
            yoe <= r[8:0];
          end
          state <= date_ok ? ST_MAC : ST_OUT;
        end
        ST_MAC: begin
          acc  <= sum;
          step <= step + 4'd1;
          if (step == STEP_LAST) state <= ST_OUT;
        end
        ST_OUT: begin
          if (done) begin
            m_tuser  <= ok;
            m_tdata  <= ok ? {1'b0, acc[38:0]} : '0;
            state    <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  `ISO8601_ASSERT_IMP(a_start_idle, start, state == ST_IDLE)
  `ISO8601_ASSERT_NXT(a_done_loads, done, m_tvalid)
  `ISO8601_ASSERT_IMP(a_invalid_zero, m_tvalid && !m_tuser, m_tdata == '0)
  `ISO8601_ASSERT_IMP(a_step_range, state == ST_MAC, step <= STEP_LAST)

endmodule

@@ rtl/core/iso8601_timestamp_to_epoch.sv @@
// ISO 8601 timestamp to Unix epoch seconds converter, top level.
// Depends on iso8601_pkg, iso8601_parse and iso8601_epoch.
//
// Takes one character per cycle on the slave side, tlast on the final one.
// Accepts "YYYY-MM-DDTHH:MM:SSZ" (20 chars) or "...+HH:MM"/"...-HH:MM" (25 chars)
// and returns one transfer per string: tuser is the valid flag, tdata the signed
// UTC seconds (zero when invalid). After the last character the input is held off
// while the sequencer works: the era division by repeated subtraction, the range
// checks, the steps on the shared multiply-accumulate unit (skipped for an invalid
// string), then loading the output register, which waits while that register is
// still full. Characters stream in at one per cycle otherwise.
module iso8601_timestamp_to_epoch (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] char_byte
  input  logic        s_tlast,   // last_char
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // [38:0] epoch_seconds, [39] zero
  output logic        m_tuser    // valid_res
);
  import iso8601_pkg::*;

  parse_t fields;
  logic   start;
  logic   done;

  iso8601_parse u_parse (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .done     (done),
    .start    (start),
    .fields   (fields)
  );

  iso8601_epoch u_epoch (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .fields   (fields),
    .done     (done),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

endmodule
